// ----- hw/rtl/gpg_pkg.sv -----
// ----------------------------------------------------------------------------
// gpg_pkg
// shared types and fixed-point constants of the gait phase generator
// ----------------------------------------------------------------------------
`default_nettype none

package gpg_pkg;

    // divider datapath
    localparam int DIV_DEN_W  = 18;
    localparam int DIV_STEP_W = 5;
    localparam logic [DIV_STEP_W-1:0] DIV_STEPS_32 = 5'd16;

    // masks reported on the result channel
    localparam int MASK_W = 8;

    // fixed-point limits
    localparam logic [15:0] SPEED_STILL_MAX = 16'd2;
    localparam logic [15:0] SPEED_MAX_FLOOR = 16'd26;
    localparam logic [17:0] FACTOR_MIN      = 18'd19661;
    localparam logic [17:0] FACTOR_MAX      = 18'd131072;
    localparam logic [13:0] PERIOD_MIN      = 14'd819;
    localparam logic [13:0] PERIOD_MAX      = 14'd12288;
    localparam logic [8:0]  DUTY_FULL       = 9'd256;

    // configuration register indexes
    localparam logic [2:0] REG_CYCLE_TIME  = 3'd0;
    localparam logic [2:0] REG_SPEED_MAX   = 3'd1;
    localparam logic [2:0] REG_DUTY_FACTOR = 3'd2;
    localparam logic [2:0] REG_LEG_COUNT   = 3'd3;
    localparam logic [2:0] REG_LEG_OFFSETS = 3'd4;

    typedef struct packed {
        logic [15:0] delta_time;
        logic [15:0] speed_now;
    } t_in_item;

    typedef struct packed {
        logic [15:0] gait_phase;
        logic [7:0]  swing_mask;
        logic [7:0]  liftoff_mask;
        logic [7:0]  touchdown_mask;
        logic        moving;
    } t_out_item;

    typedef struct packed {
        logic                  start;
        logic                  odd;
        logic [DIV_STEP_W-1:0] steps;
        logic [15:0]           num;
        logic [DIV_DEN_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_rsp;

    typedef struct packed {
        logic       start;
        logic [8:0] duty;
        logic [3:0] leg_count;
    } t_leg_req;

    typedef struct packed {
        logic              done;
        logic [MASK_W-1:0] swing;
        logic [MASK_W-1:0] lift;
        logic [MASK_W-1:0] touch;
    } t_leg_rsp;

endpackage

`default_nettype wire

// ----- hw/rtl/gpg_stream_if.sv -----
// ----------------------------------------------------------------------------
// gpg_stream_if
// valid/ready channel carrying one payload item per handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface gpg_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gpg_divider.sv -----
// ----------------------------------------------------------------------------
// gpg_divider
// restoring divider, two quotient bits per cycle, numerator fed msb first
// ----------------------------------------------------------------------------
`default_nettype none

module gpg_divider #(
    parameter int Q_W = 18
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gpg_pkg::t_div_req i_req,
    output gpg_pkg::t_div_rsp      o_rsp,
    output logic [Q_W-1:0]         o_quo
);
    import gpg_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic [17:0]           r_num;
    logic [DIV_DEN_W-1:0]  r_rem;
    logic [DIV_DEN_W-1:0]  r_den;
    logic [Q_W-1:0]        r_quo;
    logic                  r_ovf;

    logic [DIV_DEN_W:0]    t1;
    logic [DIV_DEN_W:0]    t2;
    logic                  ge1;
    logic                  ge2;
    logic [DIV_DEN_W-1:0]  r1;
    logic [DIV_DEN_W-1:0]  n_rem;

    // two dependent trial subtractions per cycle
    always_comb begin
        t1  = {r_rem, r_num[17]};
        ge1 = (t1 >= {1'b0, r_den});
        r1  = ge1 ? DIV_DEN_W'(t1 - {1'b0, r_den}) : DIV_DEN_W'(t1);
        t2  = {r1, r_num[16]};
        ge2 = (t2 >= {1'b0, r_den});
        n_rem = ge2 ? DIV_DEN_W'(t2 - {1'b0, r_den}) : DIV_DEN_W'(t2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_req.steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            // an odd bit count gets one leading zero digit
            r_num <= i_req.odd ? {1'b0, i_req.num, 1'b0} : {i_req.num, 2'b00};
            r_rem <= '0;
            r_den <= i_req.den;
            r_quo <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_num <= {r_num[15:0], 2'b00};
            r_rem <= n_rem;
            r_quo <= {r_quo[Q_W-3:0], ge1, ge2};
            r_ovf <= r_ovf | r_quo[Q_W-1] | r_quo[Q_W-2];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_quo      = r_quo;

endmodule

`default_nettype wire

// ----- hw/rtl/gpg_legs.sv -----
// ----------------------------------------------------------------------------
// gpg_legs
// leg scanner: one leg per cycle, builds swing and edge masks
// ----------------------------------------------------------------------------
`default_nettype none

module gpg_legs #(
    parameter int MAX_LEGS   = 8,
    parameter int PHASE_BITS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire gpg_pkg::t_leg_req       i_req,
    input  wire logic [8*MAX_LEGS-1:0]   i_offsets,
    input  wire logic [PHASE_BITS-1:0]   i_phase,
    output gpg_pkg::t_leg_rsp            o_rsp
);
    import gpg_pkg::*;

    localparam int LI_W = (MAX_LEGS > 1) ? $clog2(MAX_LEGS) : 1;

    logic                  r_busy;
    logic                  r_done;
    logic [LI_W-1:0]       r_li;
    logic [8*MAX_LEGS-1:0] r_off_sh;
    logic [MAX_LEGS-1:0]   r_acc_sw;
    logic [MAX_LEGS-1:0]   r_acc_lift;
    logic [MAX_LEGS-1:0]   r_acc_touch;
    logic [MAX_LEGS-1:0]   r_leg_swing;

    logic [8:0]            duty_sat;
    logic [PHASE_BITS:0]   thr;
    logic [PHASE_BITS-1:0] leg_phase;
    logic                  active;
    logic                  now_sw;
    logic                  was_sw;
    logic [MAX_LEGS-1:0]   n_sw;
    logic [MAX_LEGS-1:0]   n_lift;
    logic [MAX_LEGS-1:0]   n_touch;

    always_comb begin
        duty_sat  = (i_req.duty > DUTY_FULL) ? DUTY_FULL : i_req.duty;
        // a zero duty gives a threshold of one full cycle
        thr       = (PHASE_BITS+1)'(DUTY_FULL - duty_sat) << (PHASE_BITS - 8);
        leg_phase = i_phase + (PHASE_BITS'(r_off_sh[7:0]) << (PHASE_BITS - 8));
        active    = (4'(r_li) < i_req.leg_count);
        now_sw    = active && ({1'b0, leg_phase} < thr);
        was_sw    = r_leg_swing[r_li];
        n_sw      = r_acc_sw;
        n_lift    = r_acc_lift;
        n_touch   = r_acc_touch;
        n_sw[r_li]    = now_sw;
        n_lift[r_li]  = now_sw && !was_sw;
        n_touch[r_li] = active && !now_sw && was_sw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
            r_li        <= '0;
            r_leg_swing <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_li   <= '0;
        end else if (r_busy) begin
            if (r_li == LI_W'(MAX_LEGS - 1)) begin
                r_busy      <= 1'b0;
                r_done      <= 1'b1;
                r_leg_swing <= n_sw;
            end else begin
                r_li <= r_li + 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_off_sh    <= i_offsets;
            r_acc_sw    <= '0;
            r_acc_lift  <= '0;
            r_acc_touch <= '0;
        end else if (r_busy) begin
            r_off_sh    <= r_off_sh >> 8;
            r_acc_sw    <= n_sw;
            r_acc_lift  <= n_lift;
            r_acc_touch <= n_touch;
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.swing = MASK_W'(r_acc_sw);
    assign o_rsp.lift  = MASK_W'(r_acc_lift);
    assign o_rsp.touch = MASK_W'(r_acc_touch);

endmodule

`default_nettype wire

// ----- hw/rtl/gait_phase_generator_top.sv -----
// ----------------------------------------------------------------------------
// gait_phase_generator_top
// gait phase oscillator: speed-scaled period, phase advance, per-leg swing
// ----------------------------------------------------------------------------
// latency of a moving item: three serial divisions at two quotient bits a cycle, then a
// leg scan at one leg a cycle; a standing item skips the divisions and only scans legs
// one item in flight; the next is taken the cycle after its result is registered
// synchronous reset restores the register defaults, zero phase, all legs in stance
`default_nettype none

module gait_phase_generator_top #(
    parameter int MAX_LEGS   = 8,
    parameter int PHASE_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    gpg_stream_if.sink         i_item,
    gpg_stream_if.source       o_result,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [63:0]   i_cfg_data
);
    import gpg_pkg::*;

    localparam int INC_BITS  = PHASE_BITS + 12;
    localparam int INC_STEPS = (INC_BITS + 1) / 2;
    localparam int Q_W       = (PHASE_BITS > 18) ? PHASE_BITS : 18;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV_F = 3'd1;
    localparam logic [2:0] S_DIV_P = 3'd2;
    localparam logic [2:0] S_DIV_I = 3'd3;
    localparam logic [2:0] S_LEGS  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [15:0]           r_cycle_time;
    logic [15:0]           r_speed_max;
    logic [8:0]            r_duty_factor;
    logic [3:0]            r_leg_count;
    logic [8*MAX_LEGS-1:0] r_leg_offsets;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [PHASE_BITS-1:0] r_phase;
    logic [15:0]           r_dt;
    logic                  r_moving;
    logic                  r_out_valid;
    t_out_item             r_out_data;

    t_div_req              div_req;
    t_div_rsp              div_rsp;
    logic [Q_W-1:0]        div_quo;
    t_leg_req              leg_req;
    t_leg_rsp              leg_rsp;

    logic                  accept;
    logic                  still;
    logic [15:0]           speed_max_fl;
    logic [17:0]           factor;
    logic [13:0]           period;
    logic [15:0]           gait_phase_q;
    logic                  out_free;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_time  <= 16'd4096;
            r_speed_max   <= 16'd512;
            r_duty_factor <= 9'd154;
            r_leg_count   <= 4'd2;
            r_leg_offsets <= (8*MAX_LEGS)'(64'd32768);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CYCLE_TIME:  r_cycle_time  <= i_cfg_data[15:0];
                REG_SPEED_MAX:   r_speed_max   <= i_cfg_data[15:0];
                REG_DUTY_FACTOR: r_duty_factor <= i_cfg_data[8:0];
                REG_LEG_COUNT:   r_leg_count   <= i_cfg_data[3:0];
                REG_LEG_OFFSETS: r_leg_offsets <= i_cfg_data[8*MAX_LEGS-1:0];
                default: ;
            endcase
        end
    end

    assign accept   = i_item.valid && i_item.ready;
    assign still    = (i_item.data.speed_now <= SPEED_STILL_MAX);
    assign out_free = !r_out_valid || o_result.ready;
    assign i_item.ready = (r_state == S_IDLE);

    always_comb begin
        speed_max_fl = (r_speed_max < SPEED_MAX_FLOOR) ? SPEED_MAX_FLOOR : r_speed_max;

        if (div_rsp.ovf || (div_quo > Q_W'(FACTOR_MAX))) begin
            factor = FACTOR_MAX;
        end else if (div_quo < Q_W'(FACTOR_MIN)) begin
            factor = FACTOR_MIN;
        end else begin
            factor = div_quo[17:0];
        end

        if (div_rsp.ovf || (div_quo > Q_W'(PERIOD_MAX))) begin
            period = PERIOD_MAX;
        end else if (div_quo < Q_W'(PERIOD_MIN)) begin
            period = PERIOD_MIN;
        end else begin
            period = div_quo[13:0];
        end
    end

    // sequencer
    always_comb begin
        n_state       = r_state;
        div_req.start = 1'b0;
        div_req.odd   = 1'b0;
        div_req.steps = DIV_STEPS_32;
        div_req.num   = i_item.data.speed_now;
        div_req.den   = DIV_DEN_W'(speed_max_fl);
        leg_req.start     = 1'b0;
        leg_req.duty      = r_duty_factor;
        leg_req.leg_count = r_leg_count;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (still) begin
                        leg_req.start = 1'b1;
                        n_state       = S_LEGS;
                    end else begin
                        div_req.start = 1'b1;
                        n_state       = S_DIV_F;
                    end
                end
            end
            S_DIV_F: begin
                div_req.num = r_cycle_time;
                div_req.den = factor;
                if (div_rsp.done) begin
                    div_req.start = 1'b1;
                    n_state       = S_DIV_P;
                end
            end
            S_DIV_P: begin
                div_req.num   = r_dt;
                div_req.den   = DIV_DEN_W'(period);
                div_req.steps = DIV_STEP_W'(INC_STEPS);
                div_req.odd   = (INC_BITS % 2) != 0;
                if (div_rsp.done) begin
                    div_req.start = 1'b1;
                    n_state       = S_DIV_I;
                end
            end
            S_DIV_I: begin
                if (div_rsp.done) begin
                    leg_req.start = 1'b1;
                    n_state       = S_LEGS;
                end
            end
            S_LEGS: begin
                if (leg_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // phase wraps modulo one through the truncated quotient
            if (r_state == S_DIV_I && div_rsp.done) begin
                r_phase <= r_phase + div_quo[PHASE_BITS-1:0];
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dt     <= i_item.data.delta_time;
            r_moving <= !still;
        end
        if (r_state == S_OUT && out_free) begin
            r_out_data.gait_phase     <= gait_phase_q;
            r_out_data.swing_mask     <= leg_rsp.swing;
            r_out_data.liftoff_mask   <= leg_rsp.lift;
            r_out_data.touchdown_mask <= leg_rsp.touch;
            r_out_data.moving         <= r_moving;
        end
    end

    generate
        if (PHASE_BITS >= 16) begin : g_phase_trunc
            assign gait_phase_q = r_phase[PHASE_BITS-1 -: 16];
        end else begin : g_phase_fill
            assign gait_phase_q = {r_phase, {(16-PHASE_BITS){1'b0}}};
        end
    endgenerate

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_data;

    gpg_divider #(
        .Q_W (Q_W)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp),
        .o_quo   (div_quo)
    );

    gpg_legs #(
        .MAX_LEGS   (MAX_LEGS),
        .PHASE_BITS (PHASE_BITS)
    ) u_legs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (leg_req),
        .i_offsets (r_leg_offsets),
        .i_phase   (r_phase),
        .o_rsp     (leg_rsp)
    );

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("item accepted but sequencer stayed idle");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV_F || r_state == S_DIV_P || r_state == S_DIV_I))
        else $error("divider finished outside a division state");

    a_leg_done_in_legs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        leg_rsp.done |-> (r_state == S_LEGS))
        else $error("leg scan finished outside the leg state");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result registered outside the output state");

endmodule

`default_nettype wire
